@@ rtl/csri_pkg.sv @@
package csri_pkg;

    localparam int CORNER_CNT  = 8;
    localparam int EDGE_CNT    = 12;
    localparam int GROUP_SIZE  = 7;
    localparam int GROUP_CNT   = 2;
    localparam int TWIST_RANKS = 2187;
    localparam int FLIP_BITS   = 7;
    localparam int HIGH_GROUP_FIRST = 5;

    localparam int CP_W    = 3;   // corner piece code
    localparam int TW_W    = 2;   // corner twist code
    localparam int EP_W    = 4;   // edge piece code / edge position
    localparam int TRANK_W = 12;  // twist rank, max 2186
    localparam int CPR_W   = 16;  // corner perm rank, max 40319
    localparam int EPR_W   = 22;  // edge partial rank, max 3991679

    typedef struct packed {
        logic [23:0] corner_pieces;
        logic [15:0] corner_twists;
        logic [47:0] edge_pieces;
        logic [11:0] edge_flips;
    } t_in_beat;

    typedef struct packed {
        logic [26:0] corner_rank;
        logic [28:0] edge_rank_low_group;
        logic [28:0] edge_rank_high_group;
    } t_out_beat;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    function automatic logic [3:0] count_ones8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 8; b++) begin
            n = n + 4'(v[b]);
        end
        return n;
    endfunction

    function automatic logic [3:0] count_ones12(input logic [11:0] v);
        logic [3:0] n;
        n = '0;
        for (int b = 0; b < 12; b++) begin
            n = n + 4'(v[b]);
        end
        return n;
    endfunction

    // factorial weight of a corner Lehmer digit
    function automatic logic [CPR_W-1:0] fact_weight(input int n);
        logic [CPR_W-1:0] w;
        case (n)
            2:       w = 16'd2;
            3:       w = 16'd6;
            4:       w = 16'd24;
            5:       w = 16'd120;
            6:       w = 16'd720;
            7:       w = 16'd5040;
            default: w = 16'd1;
        endcase
        return w;
    endfunction

    function automatic logic [TRANK_W-1:0] pow3(input int n);
        logic [TRANK_W-1:0] w;
        case (n)
            1:       w = 12'd3;
            2:       w = 12'd9;
            3:       w = 12'd27;
            4:       w = 12'd81;
            5:       w = 12'd243;
            6:       w = 12'd729;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // P(11-k, 6-k)
    function automatic logic [EPR_W-1:0] part_weight(input int k);
        logic [EPR_W-1:0] w;
        case (k)
            0:       w = 22'd332640;
            1:       w = 22'd30240;
            2:       w = 22'd3024;
            3:       w = 22'd336;
            4:       w = 22'd42;
            5:       w = 22'd6;
            default: w = 22'd1;
        endcase
        return w;
    endfunction

    function automatic logic [EP_W-1:0] group_first(input int g);
        return (g == 0) ? 4'd0 : 4'(HIGH_GROUP_FIRST);
    endfunction

endpackage

@@ rtl/cube_state_rank_index_unit.sv @@
// Three register stages lie between input beat and result beat.
// Throughput: one beat per cycle while the output is not stalled; each stage
// holds while the one after it is full and stalled, so the input is refused
// only when all three stages are full. Reset (i_rst_n low, synchronous) empties
// the pipeline; payload registers keep whatever they hold.
module cube_state_rank_index_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  csri_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csri_pkg::t_out_beat o_out_beat
);

    csri_pkg::t_pipe_en en;
    logic [26:0]        corner_rank;
    logic [28:0]        low_rank;
    logic [28:0]        high_rank;

    csri_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_en        (en)
    );

    csri_corner_path u_corner (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pieces (i_in_beat.corner_pieces),
        .i_twists (i_in_beat.corner_twists),
        .o_rank   (corner_rank)
    );

    csri_edge_path u_edge (
        .i_clk       (i_clk),
        .i_en        (en),
        .i_pieces    (i_in_beat.edge_pieces),
        .i_flips     (i_in_beat.edge_flips),
        .o_low_rank  (low_rank),
        .o_high_rank (high_rank)
    );

    always_comb begin
        o_out_beat.corner_rank          = corner_rank;
        o_out_beat.edge_rank_low_group  = low_rank;
        o_out_beat.edge_rank_high_group = high_rank;
    end

endmodule

@@ rtl/csri_pipe_ctrl.sv @@
module csri_pipe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output csri_pkg::t_pipe_en  o_en
);

    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    // a stage can load when empty or when its beat moves on
    assign rdy3 = !r_v3 || i_out_ready;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign o_in_ready  = rdy1;
    assign o_out_valid = r_v3;
    assign o_en.s1     = rdy1 && i_in_valid;
    assign o_en.s2     = rdy2 && r_v1;
    assign o_en.s3     = rdy3 && r_v2;

endmodule

@@ rtl/csri_corner_path.sv @@
module csri_corner_path (
    input  logic                i_clk,
    input  csri_pkg::t_pipe_en  i_en,
    input  logic [23:0]         i_pieces,
    input  logic [15:0]         i_twists,
    output logic [26:0]         o_rank
);

    localparam int DIGITS = csri_pkg::CORNER_CNT - 1;

    logic [DIGITS-1:0][csri_pkg::CP_W-1:0] r1_digit, n1_digit;
    logic [csri_pkg::TRANK_W-1:0]          r1_trank, n1_trank;
    logic [csri_pkg::CPR_W-1:0]            r2_prank, n2_prank;
    logic [csri_pkg::TRANK_W-1:0]          r2_trank;
    logic [26:0]                           r3_rank;

    // stage 1: Lehmer digits and twist rank
    always_comb begin
        logic [7:0]                seen;
        logic [7:0]                below;
        logic [csri_pkg::CP_W-1:0] c;
        logic [3:0]                cnt;
        seen     = '0;
        n1_trank = '0;
        for (int i = 0; i < DIGITS; i++) begin
            c           = i_pieces[csri_pkg::CP_W*i +: csri_pkg::CP_W];
            below       = (8'd1 << c) - 8'd1;
            cnt         = csri_pkg::count_ones8(seen & below);
            n1_digit[i] = c - cnt[csri_pkg::CP_W-1:0];
            seen        = seen | (8'd1 << c);
            n1_trank    = n1_trank
                        + csri_pkg::TRANK_W'(i_twists[csri_pkg::TW_W*i +: csri_pkg::TW_W])
                        * csri_pkg::pow3(DIGITS - 1 - i);
        end
    end

    // stage 2: weighted digit sum
    always_comb begin
        n2_prank = '0;
        for (int i = 0; i < DIGITS; i++) begin
            n2_prank = n2_prank + csri_pkg::CPR_W'(r1_digit[i])
                     * csri_pkg::fact_weight(DIGITS - i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_digit <= n1_digit;
            r1_trank <= n1_trank;
        end
        if (i_en.s2) begin
            r2_prank <= n2_prank;
            r2_trank <= r1_trank;
        end
        // stage 3: one 16x12 multiply and add
        if (i_en.s3) begin
            r3_rank <= 27'(28'(r2_prank) * 28'(csri_pkg::TWIST_RANKS) + 28'(r2_trank));
        end
    end

    assign o_rank = r3_rank;

endmodule

@@ rtl/csri_edge_path.sv @@
module csri_edge_path (
    input  logic                i_clk,
    input  csri_pkg::t_pipe_en  i_en,
    input  logic [47:0]         i_pieces,
    input  logic [11:0]         i_flips,
    output logic [28:0]         o_low_rank,
    output logic [28:0]         o_high_rank
);

    localparam int G  = csri_pkg::GROUP_CNT;
    localparam int K  = csri_pkg::GROUP_SIZE;
    localparam int PW = csri_pkg::EP_W;

    logic [G-1:0][K-1:0][PW-1:0]                  r1_where, n1_where;
    logic [csri_pkg::EDGE_CNT-1:0]                r1_flips;
    logic [G-1:0][K-1:0][PW-1:0]                  r2_digit, n2_digit;
    logic [G-1:0][csri_pkg::FLIP_BITS-1:0]        r2_frank, n2_frank;
    logic [G-1:0][csri_pkg::EPR_W-1:0]            n3_prank;
    logic [G-1:0][28:0]                           r3_rank;

    // stage 1: locate each piece of both groups; last matching position wins
    always_comb begin
        logic [PW-1:0] target;
        for (int g = 0; g < G; g++) begin
            for (int k = 0; k < K; k++) begin
                target         = csri_pkg::group_first(g) + PW'(k);
                n1_where[g][k] = '0;
                for (int i = 0; i < csri_pkg::EDGE_CNT; i++) begin
                    if (i_pieces[PW*i +: PW] == target) begin
                        n1_where[g][k] = PW'(i);
                    end
                end
            end
        end
    end

    // stage 2: partial-permutation digits and flip bits
    always_comb begin
        logic [csri_pkg::EDGE_CNT-1:0] seen;
        logic [csri_pkg::EDGE_CNT-1:0] below;
        logic [PW-1:0]                 pos;
        for (int g = 0; g < G; g++) begin
            seen = '0;
            for (int k = 0; k < K; k++) begin
                pos             = r1_where[g][k];
                below           = (12'd1 << pos) - 12'd1;
                n2_digit[g][k]  = pos - csri_pkg::count_ones12(seen & below);
                n2_frank[g][k]  = r1_flips[pos];
                seen            = seen | (12'd1 << pos);
            end
        end
    end

    // stage 3: constant-weight sum
    always_comb begin
        for (int g = 0; g < G; g++) begin
            n3_prank[g] = '0;
            for (int k = 0; k < K; k++) begin
                n3_prank[g] = n3_prank[g] + csri_pkg::EPR_W'(r2_digit[g][k])
                            * csri_pkg::part_weight(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r1_where <= n1_where;
            r1_flips <= i_flips;
        end
        if (i_en.s2) begin
            r2_digit <= n2_digit;
            r2_frank <= n2_frank;
        end
        if (i_en.s3) begin
            for (int g = 0; g < G; g++) begin
                r3_rank[g] <= {n3_prank[g], r2_frank[g]};
            end
        end
    end

    assign o_low_rank  = r3_rank[0];
    assign o_high_rank = r3_rank[1];

endmodule

@@ rtl/csri_checker.sv @@
module csri_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input csri_pkg::t_out_beat o_out_beat
);

    // stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_beat))
        else $error("result beat changed while stalled");

    // input is only refused when the whole pipe is backed up
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input refused with room in the pipe");

    // a result appearing on an idle output must match an earlier accepted input beat
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 3))
        else $error("result beat without matching input beat");

endmodule

bind cube_state_rank_index_unit csri_checker u_csri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
